### rtl/trrx_pkg.sv
// ----------------------------------------------------------------------------
// trrx_pkg
// Shared constants and types of the tag run range extractor.
// ----------------------------------------------------------------------------
package trrx_pkg;

	// number of tags the design is built for, 1 to 64
	localparam int TAG_COUNT = 32;

	localparam int HW_TAGS = 32;
	localparam int OFF_W   = 31;
	localparam int IDX_W   = 5;

	// tags above the width of the tag bitset are never present
	localparam int ACTIVE_TAGS = (TAG_COUNT > HW_TAGS) ? HW_TAGS : TAG_COUNT;

	localparam logic [HW_TAGS-1:0] ACTIVE_MASK = (ACTIVE_TAGS == HW_TAGS) ?
		{HW_TAGS{1'b1}} :
		HW_TAGS'((64'd1 << ACTIVE_TAGS) - 64'd1);

	typedef logic [HW_TAGS-1:0] tag_mask_t;
	typedef logic [OFF_W-1:0]   offset_t;
	typedef logic [IDX_W-1:0]   tag_idx_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic emit;
	} trrx_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_work;
		logic slot_free;
		logic last_pick;
	} trrx_stat_t;

endpackage

### rtl/trrx_in_if.sv
// ----------------------------------------------------------------------------
// trrx_in_if
// Byte channel: offset, tag bitset and end-of-write mark.
// ----------------------------------------------------------------------------
interface trrx_in_if
	import trrx_pkg::*;
();
	logic      valid;
	logic      ready;
	offset_t   offset;
	tag_mask_t tag_bits;
	logic      last_byte;

	modport source (output valid, output offset, output tag_bits, output last_byte,
		input ready);
	modport sink (input valid, input offset, input tag_bits, input last_byte,
		output ready);
endinterface

### rtl/trrx_out_if.sv
// ----------------------------------------------------------------------------
// trrx_out_if
// Range channel: tag, run start, run length and end-of-burst mark.
// ----------------------------------------------------------------------------
interface trrx_out_if
	import trrx_pkg::*;
();
	logic     valid;
	logic     ready;
	tag_idx_t tag_index;
	offset_t  range_start;
	offset_t  range_length;
	logic     end_of_burst;

	modport source (output valid, output tag_index, output range_start,
		output range_length, output end_of_burst, input ready);
	modport sink (input valid, input tag_index, input range_start,
		input range_length, input end_of_burst, output ready);
endinterface

### rtl/tag_run_range_extractor_top.sv
// ----------------------------------------------------------------------------
// tag_run_range_extractor_top
// Turns a stream of tagged file bytes into per-tag ranges of consecutive bytes.
// ----------------------------------------------------------------------------
// channel  role    payload
// bytes    sink    offset[31], tag_bits[32], last_byte
// ranges   source  tag_index[5], range_start[31], range_length[31], end_of_burst
//
// a byte that ends no run is taken alone; after a byte that ends k runs its
// k ranges leave one per cycle through the output register while it is free
// the ranges of a byte go out closed runs first, then flushed runs, each by tag
// a stall on ranges holds the walk; the next byte is taken once the last range
// of the current byte sits in the output register
// reset clears all run and pending state; run start offsets need no reset
module tag_run_range_extractor_top
	import trrx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	trrx_in_if.sink    bytes,
	trrx_out_if.source ranges
);

	trrx_cmd_t  cmd;
	trrx_stat_t stat;

	trrx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bytes.valid),
		.in_ready (bytes.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	trrx_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.offset       (bytes.offset),
		.tag_bits     (bytes.tag_bits),
		.last_byte    (bytes.last_byte),
		.cmd          (cmd),
		.stat         (stat),
		.out_ready    (ranges.ready),
		.out_valid    (ranges.valid),
		.tag_index    (ranges.tag_index),
		.range_start  (ranges.range_start),
		.range_length (ranges.range_length),
		.end_of_burst (ranges.end_of_burst)
	);

endmodule

### rtl/trrx_ctrl.sv
// ----------------------------------------------------------------------------
// trrx_ctrl
// Controller: takes a byte, then walks the ended runs one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module trrx_ctrl
	import trrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  trrx_stat_t stat,
	output trrx_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = in_valid && in_ready;
	assign cmd.emit = (state_q == ST_SCAN) && stat.slot_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && stat.has_work)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (cmd.emit && stat.last_pick)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### rtl/trrx_dp.sv
// ----------------------------------------------------------------------------
// trrx_dp
// Datapath: per-tag run state, pending range masks and output register.
// ----------------------------------------------------------------------------
module trrx_dp
	import trrx_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  offset_t    offset,
	input  tag_mask_t  tag_bits,
	input  logic       last_byte,
	input  trrx_cmd_t  cmd,
	output trrx_stat_t stat,
	input  logic       out_ready,
	output logic       out_valid,
	output tag_idx_t   tag_index,
	output offset_t    range_start,
	output offset_t    range_length,
	output logic       end_of_burst
);

	tag_mask_t open_q;
	tag_mask_t close_q;
	tag_mask_t flush_q;
	offset_t   off_q;
	offset_t   begin_q [HW_TAGS];
	logic      out_valid_q;
	tag_idx_t  tag_q;
	offset_t   start_q;
	offset_t   len_q;
	logic      eob_q;

	tag_mask_t bits_act;
	tag_mask_t close_d;
	tag_mask_t flush_d;
	tag_mask_t starts;
	logic      use_close;
	tag_mask_t sel;
	tag_mask_t pick;
	tag_mask_t rest;
	tag_idx_t  idx;
	offset_t   end_off;

	assign bits_act = tag_bits & ACTIVE_MASK;
	assign close_d  = open_q & ~bits_act;
	assign flush_d  = last_byte ? bits_act : '0;
	assign starts   = bits_act & ~open_q;

	// closed runs go out before flushed runs, each in ascending tag order
	assign use_close = |close_q;
	assign sel       = use_close ? close_q : flush_q;
	assign pick      = sel & (~sel + tag_mask_t'(1));
	assign rest      = (close_q | flush_q) & ~pick;

	always_comb begin
		idx = '0;
		for (int j = HW_TAGS - 1; j >= 0; j--) begin
			if (sel[j])
				idx = IDX_W'(j);
		end
	end

	assign end_off  = use_close ? off_q : off_q + offset_t'(1);

	assign stat.has_work  = (|close_d) || (|flush_d);
	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.last_pick = (rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= '0;
			close_q     <= '0;
			flush_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				open_q  <= last_byte ? '0 : bits_act;
				close_q <= close_d;
				flush_q <= flush_d;
			end else if (cmd.emit) begin
				if (use_close)
					close_q <= close_q & ~pick;
				else
					flush_q <= flush_q & ~pick;
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			off_q <= offset;
			for (int j = 0; j < HW_TAGS; j++) begin
				if (starts[j])
					begin_q[j] <= offset;
			end
		end
		if (cmd.emit) begin
			tag_q   <= idx;
			start_q <= begin_q[idx];
			len_q   <= end_off - begin_q[idx];
			eob_q   <= (rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign tag_index    = tag_q;
	assign range_start  = start_q;
	assign range_length = len_q;
	assign end_of_burst = eob_q;

endmodule

### dv/tag_run_range_extractor_top_tb.sv
// ----------------------------------------------------------------------------
// tag_run_range_extractor_top_tb
// Self-checking bench: feeds tagged file bytes, tracks per-tag runs itself and
// compares every emitted range, in order, against its own run bookkeeping.
// ----------------------------------------------------------------------------
module tag_run_range_extractor_top_tb
	import trrx_pkg::*;
();

	typedef struct {
		offset_t   offset;
		tag_mask_t tag_bits;
		logic      last_byte;
		bit        drain;
	} wr_byte_t;

	typedef struct {
		tag_idx_t tag;
		offset_t  start;
		offset_t  len;
		logic     eob;
	} tag_range_t;

	logic clk;
	logic arst_n;

	trrx_in_if  byte_ch();
	trrx_out_if range_ch();

	tag_run_range_extractor_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.ranges (range_ch)
	);

	// pending bytes, expected ranges, and the tracked run state
	wr_byte_t   byte_queue[$];
	tag_range_t ranges_due[$];
	bit         run_live[HW_TAGS];
	offset_t    run_first[HW_TAGS];

	wr_byte_t    on_wire;
	tag_range_t  want;
	int unsigned err_count;
	int unsigned bytes_taken;
	int unsigned tx_gap;
	int unsigned rx_gap;
	int unsigned hold_left;
	bit          hold_done;
	logic        calm;

	// both sides run without gaps for part of every hundred bytes
	assign calm = (bytes_taken % 100) >= 70;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void log_error(string msg);
		err_count++;
		if (err_count <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// closed runs first by tag, then the runs flushed by the last byte
	function automatic void track_byte(wr_byte_t b);
		tag_range_t burst[$];
		tag_range_t r;
		offset_t    stop;
		for (int j = 0; j < ACTIVE_TAGS; j++) begin
			if (b.tag_bits[j]) begin
				if (!run_live[j]) begin
					run_live[j]  = 1'b1;
					run_first[j] = b.offset;
				end
			end else if (run_live[j]) begin
				r.tag   = tag_idx_t'(j);
				r.start = run_first[j];
				r.len   = b.offset - run_first[j];
				r.eob   = 1'b0;
				burst.push_back(r);
				run_live[j] = 1'b0;
			end
		end
		if (b.last_byte) begin
			stop = b.offset + 31'd1;
			for (int j = 0; j < ACTIVE_TAGS; j++) begin
				if (run_live[j]) begin
					r.tag   = tag_idx_t'(j);
					r.start = run_first[j];
					r.len   = stop - run_first[j];
					r.eob   = 1'b0;
					burst.push_back(r);
					run_live[j] = 1'b0;
				end
			end
		end
		if (burst.size() != 0)
			burst[burst.size() - 1].eob = 1'b1;
		foreach (burst[i])
			ranges_due.push_back(burst[i]);
	endfunction

	function automatic void add_byte(offset_t off, tag_mask_t bits, logic last, bit drain = 0);
		wr_byte_t b;
		b.offset    = off;
		b.tag_bits  = bits;
		b.last_byte = last;
		b.drain     = drain;
		byte_queue.push_back(b);
	endfunction

	// one write: consecutive offsets, tags mostly carried over byte to byte
	function automatic int unsigned add_write(bit drain);
		offset_t     pos;
		tag_mask_t   bits;
		tag_mask_t   flips;
		int unsigned len;
		int unsigned density;
		bit          closed;
		case ($urandom_range(0, 3))
			0: pos = offset_t'($urandom);
			1: pos = 31'h7FFF_FFFF - offset_t'($urandom_range(0, 12));
			default: pos = offset_t'($urandom_range(0, 4095));
		endcase
		case ($urandom_range(0, 3))
			0: bits = '1;
			1: bits = $urandom;
			default: bits = $urandom & $urandom;
		endcase
		len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		density = $urandom_range(0, 2);
		closed  = $urandom_range(0, 9) != 0;
		for (int unsigned k = 0; k < len; k++) begin
			add_byte(pos, bits, closed && (k == len - 1), drain && (k == 0));
			pos   = pos + 31'd1;
			flips = $urandom & $urandom;
			if (density != 0)
				flips = flips & $urandom;
			if (density == 2)
				flips = flips & $urandom;
			bits = bits ^ flips;
		end
		return len;
	endfunction

	// byte source
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_ch.valid     <= 1'b0;
			byte_ch.offset    <= '0;
			byte_ch.tag_bits  <= '0;
			byte_ch.last_byte <= 1'b0;
			tx_gap            <= 0;
			bytes_taken       <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				track_byte(on_wire);
				bytes_taken <= bytes_taken + 1;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (tx_gap != 0) begin
					tx_gap        <= tx_gap - 1;
					byte_ch.valid <= 1'b0;
				end else if (byte_queue.size() != 0 &&
					!(byte_queue[0].drain && ranges_due.size() != 0)) begin
					on_wire = byte_queue.pop_front();
					byte_ch.valid     <= 1'b1;
					byte_ch.offset    <= on_wire.offset;
					byte_ch.tag_bits  <= on_wire.tag_bits;
					byte_ch.last_byte <= on_wire.last_byte;
					tx_gap            <= calm ? 0 : pick_gap();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// range sink, with one long hold-off while bytes keep coming
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_ch.ready <= 1'b0;
			rx_gap         <= 0;
			hold_left      <= 0;
			hold_done      <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left      <= hold_left - 1;
			range_ch.ready <= 1'b0;
		end else if (!hold_done && bytes_taken >= 120) begin
			hold_done      <= 1'b1;
			hold_left      <= 400;
			range_ch.ready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap         <= rx_gap - 1;
			range_ch.ready <= 1'b0;
		end else begin
			range_ch.ready <= 1'b1;
			rx_gap         <= calm ? 0 : pick_gap();
		end
	end

	// range checker
	always @(posedge clk) begin
		if (arst_n && range_ch.valid && range_ch.ready) begin
			if (ranges_due.size() == 0) begin
				log_error($sformatf("unexpected range tag %0d start %0d len %0d eob %0b",
					range_ch.tag_index, range_ch.range_start, range_ch.range_length,
					range_ch.end_of_burst));
			end else begin
				want = ranges_due.pop_front();
				if (range_ch.tag_index !== want.tag || range_ch.range_start !== want.start ||
					range_ch.range_length !== want.len || range_ch.end_of_burst !== want.eob)
					log_error($sformatf({"range mismatch: expected tag %0d start %0d len %0d ",
						"eob %0b, got tag %0d start %0d len %0d eob %0b"},
						want.tag, want.start, want.len, want.eob, range_ch.tag_index,
						range_ch.range_start, range_ch.range_length, range_ch.end_of_burst));
			end
		end
	end

	initial begin
		int unsigned made;
		int unsigned writes;
		int unsigned waited;
		clk                = 1'b0;
		arst_n             = 1'b0;
		byte_ch.valid      = 1'b0;
		byte_ch.offset     = '0;
		byte_ch.tag_bits   = '0;
		byte_ch.last_byte  = 1'b0;
		range_ch.ready     = 1'b0;
		err_count          = 0;
		foreach (run_live[j])
			run_live[j] = 1'b0;

		// every tag opens, then all close at once
		add_byte(31'd0, '1, 1'b0);
		add_byte(31'd1, '0, 1'b0);
		// interleaved tags, then a flush of all 32 runs
		add_byte(31'd2, 32'hAAAA_AAAA, 1'b0);
		add_byte(31'd3, 32'h5555_5555, 1'b0);
		add_byte(31'd4, '1, 1'b1);
		// last byte with nothing open
		add_byte(31'd10, '0, 1'b1);
		// flush at the top offset, end offset wraps to zero
		add_byte(31'h7FFF_FFFF, 32'h8000_0001, 1'b1);
		// offsets going backward: wrapped and zero lengths
		add_byte(31'd100, 32'h0000_0001, 1'b0);
		add_byte(31'd50, '0, 1'b0);
		add_byte(31'd7, 32'h0000_0002, 1'b0);
		add_byte(31'd7, '0, 1'b0);
		// closes and flushes from the same byte, sender waits for a quiet block
		add_byte(31'd200, 32'h0000_00F0, 1'b0, 1);
		add_byte(31'd201, 32'h0000_000F, 1'b1);
		add_byte(31'h7FFF_FFFE, 32'h7FFF_FFFF, 1'b1);
		add_byte(31'h2AAA_AAAA, 32'hFFFF_0000, 1'b0);
		add_byte(31'h5555_5555, 32'h0000_FFFF, 1'b1);

		made   = 0;
		writes = 0;
		while (made < 260) begin
			if ($urandom_range(0, 6) == 0) begin
				add_byte(offset_t'($urandom), $urandom, $urandom_range(0, 3) == 0);
				made++;
			end else begin
				made += add_write(writes == 10 || $urandom_range(0, 29) == 0);
				writes++;
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || byte_ch.valid)
			@(posedge clk);
		waited = 0;
		while (ranges_due.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (ranges_due.size() != 0)
			log_error($sformatf("%0d ranges never emitted", ranges_due.size()));
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
